@@ src/dca_pkg.sv @@
// Shared types and constants for the daylight-saving clock adjuster.
// No dependencies; every other file imports this package.
package dca_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register word indexes (paddr[3:2])
    localparam logic [1:0] REG_REGION  = 2'd0;
    localparam logic [1:0] REG_ENABLE  = 2'd1;
    localparam logic [1:0] REG_FWD_HR  = 2'd2;

    localparam logic       REGION_EU   = 1'b0;
    localparam logic       REGION_US   = 1'b1;

    localparam logic       OP_TICK     = 1'b0;
    localparam logic       OP_STARTUP  = 1'b1;

    localparam logic [3:0] MONTH_MAR   = 4'd3;
    localparam logic [3:0] MONTH_APR   = 4'd4;
    localparam logic [3:0] MONTH_SEP   = 4'd9;
    localparam logic [3:0] MONTH_OCT   = 4'd10;
    localparam logic [3:0] MONTH_NOV   = 4'd11;

    localparam logic [2:0] SUNDAY      = 3'd7;
    localparam logic [4:0] US_SWITCH_HR = 5'd2;
    localparam logic [4:0] FWD_HR_RESET = 5'd2;
    localparam logic [4:0] HOURS_MAX   = 5'd23;

    typedef struct packed {
        logic       opcode;
        logic [3:0] month_num;
        logic [4:0] day_of_month;
        logic [2:0] day_of_week;
        logic [4:0] hour_in;
        logic [5:0] minute_in;
        logic [5:0] second_in;
        logic       saved_status;
    } in_item_t;

    typedef struct packed {
        logic [4:0] hour_out;
        logic       adjusted;
        logic       summer_flag;
    } out_item_t;

    typedef struct packed {
        logic       region_select;
        logic       feature_enable;
        logic [4:0] forward_hour;
    } cfg_t;

endpackage

@@ src/dca_cfg_regs.sv @@
// APB register file for the daylight-saving clock adjuster.
// Depends on dca_pkg for the register indexes and the cfg_t struct.
module dca_cfg_regs
    import dca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    logic [1:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.region_select  <= REGION_EU;
            cfg_reg.feature_enable <= 1'b0;
            cfg_reg.forward_hour   <= FWD_HR_RESET;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_REGION: cfg_reg.region_select  <= pwdata[0];
                REG_ENABLE: cfg_reg.feature_enable <= pwdata[0];
                REG_FWD_HR: cfg_reg.forward_hour   <= pwdata[4:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_REGION: prdata = {{(APB_DATA_W-1){1'b0}}, cfg_reg.region_select};
            REG_ENABLE: prdata = {{(APB_DATA_W-1){1'b0}}, cfg_reg.feature_enable};
            REG_FWD_HR: prdata = {{(APB_DATA_W-5){1'b0}}, cfg_reg.forward_hour};
            default:    prdata = '0;
        endcase
    end

endmodule

@@ src/dca_rules.sv @@
// Combinational EU/US summer-time decision and hour correction for one item.
// Depends on dca_pkg for the item, config types and calendar constants.
module dca_rules
    import dca_pkg::*;
(
    input  in_item_t  item,
    input  cfg_t      cfg,
    input  logic      summer_cur,
    output out_item_t result,
    output logic      summer_next
);

    logic       sunday;
    logic       flag_base;
    logic       eu_last;
    logic       us_mar_wk2;
    logic       us_nov_wk1;
    logic [5:0] fh_p1;
    logic [5:0] hr6;
    logic [5:0] dom6;
    logic [2:0] dow_mod7;
    logic [5:0] eu_span;
    logic [5:0] dow_p8;
    logic [5:0] dow_p1;
    logic       in_summer;
    logic       fwd;
    logic       back;
    logic       tick_edge;
    logic [5:0] hr_inc;
    logic [4:0] hr_dec;

    assign sunday     = (item.day_of_week == SUNDAY);
    assign hr6        = {1'b0, item.hour_in};
    assign dom6       = {1'b0, item.day_of_month};
    assign fh_p1      = {1'b0, cfg.forward_hour} + 6'd1;
    assign eu_last    = (item.day_of_month >= 5'd25);
    assign us_mar_wk2 = (item.day_of_month >= 5'd8) && (item.day_of_month <= 5'd14);
    assign us_nov_wk1 = (item.day_of_month <= 5'd7);
    assign dow_mod7   = sunday ? 3'd0 : item.day_of_week;
    // 31 - dom + (dow mod 7): days from here to month end, shifted by weekday
    assign eu_span    = {1'b0, 5'd31 - item.day_of_month} + {3'b0, dow_mod7};
    assign dow_p8     = {3'b0, item.day_of_week} + 6'd8;
    assign dow_p1     = {3'b0, item.day_of_week} + 6'd1;

    // Startup loads the saved flag before the season check
    assign flag_base  = (item.opcode == OP_STARTUP) ? item.saved_status : summer_cur;

    always_comb
    begin
        in_summer = 1'b0;
        if (cfg.region_select == REGION_EU)
        begin
            if (item.month_num >= MONTH_APR && item.month_num <= MONTH_SEP)
                in_summer = 1'b1;
            else if (item.month_num == MONTH_MAR)
            begin
                if (sunday && eu_last)
                    in_summer = (item.hour_in >= cfg.forward_hour);
                else
                    in_summer = (eu_span < 6'd7);
            end
            else if (item.month_num == MONTH_OCT)
            begin
                // Fall-back day: the repeated hour counts as summer if flagged
                if (sunday && eu_last)
                    in_summer = flag_base ? (hr6 <= fh_p1)
                                          : (item.hour_in <= cfg.forward_hour);
                else
                    in_summer = !(eu_span < 6'd7);
            end
        end
        else
        begin
            if (item.month_num >= MONTH_APR && item.month_num <= MONTH_OCT)
                in_summer = 1'b1;
            else if (item.month_num == MONTH_MAR)
            begin
                if (sunday && us_mar_wk2)
                    in_summer = (item.hour_in >= US_SWITCH_HR);
                else
                    in_summer = (dom6 >= dow_p8);
            end
            else if (item.month_num == MONTH_NOV)
            begin
                if (sunday && us_nov_wk1)
                    in_summer = flag_base ? (item.hour_in <= US_SWITCH_HR + 5'd1)
                                          : (item.hour_in <= US_SWITCH_HR);
                else
                    in_summer = !(dom6 >= dow_p1);
            end
        end
    end

    assign tick_edge = cfg.feature_enable && sunday
                    && (item.minute_in == 6'd0) && (item.second_in == 6'd0);

    always_comb
    begin
        fwd  = 1'b0;
        back = 1'b0;
        if (item.opcode == OP_STARTUP)
        begin
            if (cfg.feature_enable)
            begin
                fwd  = in_summer && !flag_base;
                back = !in_summer && flag_base;
            end
        end
        else if (tick_edge)
        begin
            if (cfg.region_select == REGION_EU)
            begin
                if (!flag_base)
                    fwd  = (item.month_num == MONTH_MAR) && eu_last
                        && (item.hour_in == cfg.forward_hour);
                else
                    back = (item.month_num == MONTH_OCT) && eu_last && (hr6 == fh_p1);
            end
            else
            begin
                if (!flag_base)
                    fwd  = (item.month_num == MONTH_MAR) && us_mar_wk2
                        && (item.hour_in == US_SWITCH_HR);
                else
                    back = (item.month_num == MONTH_NOV) && us_nov_wk1
                        && (item.hour_in == US_SWITCH_HR);
            end
        end
    end

    // Wrap modulo 24; hour_in may be out of range, so reduce once
    assign hr_inc = (hr6 + 6'd1 >= 6'd24) ? hr6 + 6'd1 - 6'd24 : hr6 + 6'd1;

    always_comb
    begin
        if (item.hour_in == 5'd0)
            hr_dec = HOURS_MAX;
        else if (item.hour_in - 5'd1 >= 5'd24)
            hr_dec = item.hour_in - 5'd25;
        else
            hr_dec = item.hour_in - 5'd1;
    end

    always_comb
    begin
        summer_next = flag_base;
        result.hour_out = item.hour_in;
        if (fwd)
        begin
            summer_next     = 1'b1;
            result.hour_out = hr_inc[4:0];
        end
        else if (back)
        begin
            summer_next     = 1'b0;
            result.hour_out = hr_dec;
        end
        result.adjusted    = fwd || back;
        result.summer_flag = summer_next;
    end

endmodule

@@ src/dst_clock_adjuster_unit.sv @@
// Daylight-saving clock adjuster: one timestamp in, one corrected hour out per transfer.
// Each item is held in the input register and is then decided by the rule logic into the
// result register, so the block sustains one item per clock while the output is not
// stalled; a result is offered on the output once it is in the result register. A stalled
// result holds the input register, and then in_ready drops. The summer flag advances as each
// item leaves the input register, so back-to-back items see the flag left by the one before.
// Registers: 0x0 region (0 EU, 1 US), 0x4 enable, 0x8 EU forward hour; write them only
// while idle. Depends on dca_pkg, dca_cfg_regs and dca_rules.
module dst_clock_adjuster_unit
    import dca_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    cfg_t      cfg;
    in_item_t  item_reg;
    logic      item_vld_reg;
    out_item_t res_reg;
    logic      res_vld_reg;
    logic      summer_reg;
    out_item_t res_next;
    logic      summer_next;
    logic      advance;

    dca_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    dca_rules u_rules (
        .item        (item_reg),
        .cfg         (cfg),
        .summer_cur  (summer_reg),
        .result      (res_next),
        .summer_next (summer_next)
    );

    // Move the held item into the result register when that slot frees up
    assign advance   = item_vld_reg && (!res_vld_reg || out_ready);
    assign in_ready  = !item_vld_reg || advance;
    assign out_valid = res_vld_reg;
    assign out_data  = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
            summer_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
                item_vld_reg <= in_valid;
            if (advance)
            begin
                res_vld_reg <= 1'b1;
                summer_reg  <= summer_next;
            end
            else if (out_ready)
                res_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            item_reg <= in_data;
        if (advance)
            res_reg <= res_next;
    end

endmodule
